FILE: hw/rtl/mtg_pkg.sv
// Shared types and constants for the MT19937 generator.
package mtg_pkg;

    localparam int TABLE_WORDS = 624;
    localparam int FAR_OFFSET  = 397;
    localparam int ADDR_W      = 10;
    localparam int WORD_W      = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam addr_t LAST_ADDR   = addr_t'(TABLE_WORDS - 1);
    localparam addr_t FAR_ADDR    = addr_t'(FAR_OFFSET);
    localparam addr_t WRAP_LIMIT  = addr_t'(TABLE_WORDS - FAR_OFFSET);
    localparam addr_t WRAP_OFFSET = addr_t'(TABLE_WORDS - FAR_OFFSET);

    localparam word_t SEED_RESET = 32'd19650218;
    localparam word_t INIT_MULT  = 32'd1812433253;
    localparam word_t TWIST_XOR  = 32'h9908_B0DF;
    localparam word_t UPPER_MASK = 32'h8000_0000;
    localparam word_t LOWER_MASK = 32'h7FFF_FFFF;
    localparam word_t TEMPER_B   = 32'h9D2C_5680;
    localparam word_t TEMPER_C   = 32'hEFC6_0000;

    typedef struct packed {
        logic  we;
        addr_t addr;
        word_t data;
    } ram_wr_t;

endpackage

FILE: hw/rtl/mersenne_twister_generator_top.sv
// MT19937 generator: each draw ends in a done strobe registered from the twist state.
// A new item is accepted only in idle, not while a draw is under way.
// A reseed first refills the table one word per cycle, then passes through a read state before the twist.
// After reset the table is filled from the reset seed; busy stays high until the fill ends.
// The result is shown for one cycle with done; the receiver cannot stall it.
module mersenne_twister_generator_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  reseed_first,
    output logic                  done,
    output mtg_pkg::word_t        random_word,
    input  logic                  cfg_we,
    input  mtg_pkg::word_t        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_TWIST
    } state_t;

    state_t          state_reg, state_next;
    mtg_pkg::addr_t  pos_reg, pos_next;
    mtg_pkg::addr_t  fill_idx_reg, fill_idx_next;
    mtg_pkg::word_t  cur_reg, cur_next;
    mtg_pkg::word_t  prev_reg, prev_next;
    mtg_pkg::word_t  seed_reg, seed_next;
    mtg_pkg::word_t  word_reg, word_next;
    logic            done_reg, done_next;
    logic            pending_reg, pending_next;

    mtg_pkg::ram_wr_t ram_wr;
    mtg_pkg::addr_t   addr_next_pos;
    mtg_pkg::addr_t   addr_far;
    mtg_pkg::word_t   rd_next;
    mtg_pkg::word_t   rd_far;
    mtg_pkg::word_t   new_word;
    mtg_pkg::word_t   tempered;
    mtg_pkg::word_t   mixed;
    mtg_pkg::word_t   product;
    mtg_pkg::word_t   fill_word;

    // Neighbor and far read addresses of the current position.
    always_comb
    begin
        addr_next_pos = (pos_reg == mtg_pkg::LAST_ADDR) ? '0 : pos_reg + 1'b1;
        addr_far      = (pos_reg < mtg_pkg::WRAP_LIMIT) ? pos_reg + mtg_pkg::FAR_ADDR
                                                        : pos_reg - mtg_pkg::WRAP_OFFSET;
    end

    mtg_table_ram u_ram (
        .clk       (clk),
        .wr        (ram_wr),
        .rd_addr_a (addr_next_pos),
        .rd_addr_b (addr_far),
        .rd_data_a (rd_next),
        .rd_data_b (rd_far)
    );

    mtg_twist u_twist (
        .cur_word  (cur_reg),
        .next_word (rd_next),
        .far_word  (rd_far),
        .new_word  (new_word),
        .tempered  (tempered)
    );

    // Seed recurrence for the fill sweep; only the low word of the product is kept.
    always_comb
    begin
        mixed     = prev_reg ^ (prev_reg >> 30);
        product   = mixed * mtg_pkg::INIT_MULT;
        fill_word = product + {22'b0, fill_idx_reg};
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        fill_idx_next = fill_idx_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        seed_next     = cfg_we ? cfg_data : seed_reg;
        word_next     = word_reg;
        done_next     = 1'b0;
        pending_next  = pending_reg;
        ram_wr        = '{we: 1'b0, addr: pos_reg, data: new_word};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (reseed_first)
                    begin
                        state_next    = ST_FILL;
                        fill_idx_next = '0;
                        pending_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TWIST;
                    end
                end
            end
            ST_FILL:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = fill_idx_reg;
                ram_wr.data = (fill_idx_reg == '0) ? seed_reg : fill_word;
                prev_next   = ram_wr.data;
                if (fill_idx_reg == '0)
                begin
                    cur_next = seed_reg;
                end
                fill_idx_next = fill_idx_reg + 1'b1;
                if (fill_idx_reg == mtg_pkg::LAST_ADDR)
                begin
                    pos_next     = '0;
                    pending_next = 1'b0;
                    state_next   = pending_reg ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_TWIST;
            end
            ST_TWIST:
            begin
                ram_wr.we  = 1'b1;
                cur_next   = rd_next;
                pos_next   = addr_next_pos;
                word_next  = tempered;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            pos_reg      <= '0;
            fill_idx_reg <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            seed_reg     <= mtg_pkg::SEED_RESET;
            word_reg     <= '0;
            done_reg     <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            fill_idx_reg <= fill_idx_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
            seed_reg     <= seed_next;
            word_reg     <= word_next;
            done_reg     <= done_next;
            pending_reg  <= pending_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign random_word = word_reg;

    // A result strobe follows only a twist cycle.
    a_done_after_twist: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_TWIST))
        else $error("done without a preceding twist");

    // The position never leaves the table.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= mtg_pkg::LAST_ADDR)
        else $error("table position out of range");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // The far and neighbor reads never hit the word being written by a twist.
    a_no_twist_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TWIST) |-> (addr_next_pos != pos_reg && addr_far != pos_reg))
        else $error("twist write overlaps a read address");

endmodule

FILE: hw/rtl/mtg_table_ram.sv
// State table memory: one write port and two registered read ports.
module mtg_table_ram (
    input  logic            clk,
    input  mtg_pkg::ram_wr_t wr,
    input  mtg_pkg::addr_t  rd_addr_a,
    input  mtg_pkg::addr_t  rd_addr_b,
    output mtg_pkg::word_t  rd_data_a,
    output mtg_pkg::word_t  rd_data_b
);

    mtg_pkg::word_t mem [mtg_pkg::TABLE_WORDS];
    mtg_pkg::word_t rd_a_reg;
    mtg_pkg::word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hw/rtl/mtg_twist.sv
// Twist of one table word and tempering of the result.
module mtg_twist (
    input  mtg_pkg::word_t cur_word,
    input  mtg_pkg::word_t next_word,
    input  mtg_pkg::word_t far_word,
    output mtg_pkg::word_t new_word,
    output mtg_pkg::word_t tempered
);

    mtg_pkg::word_t mix;
    mtg_pkg::word_t mix_shift;
    mtg_pkg::word_t y1;
    mtg_pkg::word_t y2;
    mtg_pkg::word_t y3;

    always_comb
    begin
        mix       = (cur_word & mtg_pkg::UPPER_MASK) | (next_word & mtg_pkg::LOWER_MASK);
        mix_shift = (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_XOR : '0);
        new_word  = far_word ^ mix_shift;
        y1        = new_word ^ (new_word >> 11);
        y2        = y1 ^ ((y1 << 7) & mtg_pkg::TEMPER_B);
        y3        = y2 ^ ((y2 << 15) & mtg_pkg::TEMPER_C);
        tempered  = y3 ^ (y3 >> 18);
    end

endmodule
